FILE: rtl/core/segment_intersection_defines.svh
// Assertion macros for the segment intersection checker.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define SI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment_intersection check failed");

// Check a consequent in the cycle after its antecedent.
`define SI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment_intersection check failed");

`endif

FILE: rtl/core/si_pkg.sv
// Shared widths and types for the segment intersection pipeline.
// Used by si_div and segment_intersection; depends on nothing else.
package si_pkg;

	localparam int COORD_W = 16;              // Q8.8 coordinate
	localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;      // product of two differences
	localparam int DET_W   = PROD_W + 1;      // signed determinant / numerators
	localparam int DETM_W  = PROD_W;          // determinant magnitude
	localparam int MAG_W   = COORD_W;         // magnitude of a direction component
	localparam int NUM_W   = DETM_W + MAG_W;  // dividend of the point division
	localparam int QUO_W   = MAG_W;           // quotient, never above the magnitude
	localparam int THR_W   = 34;              // parallel threshold register
	localparam int IN_W    = 8 * COORD_W;
	localparam int OUT_W   = 2 * COORD_W;

	// Side information that rides along with the divider stages
	typedef struct packed {
		logic               hit;
		logic               neg_x;
		logic               neg_y;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
	} side_t;

	// Sign-extend a coordinate by one bit
	function automatic logic [DIFF_W-1:0] ext_c(input logic [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	// Sign-extend a product by one bit
	function automatic logic [DET_W-1:0] ext_p(input logic [PROD_W-1:0] v);
		return {v[PROD_W-1], v};
	endfunction

endpackage

FILE: rtl/core/si_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on si_pkg for widths and the side_t struct.
module si_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [si_pkg::DETM_W-1:0]  in_det,
	input  logic [si_pkg::NUM_W-1:0]   in_num_x,
	input  logic [si_pkg::NUM_W-1:0]   in_num_y,
	input  si_pkg::side_t              in_side,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [si_pkg::QUO_W-1:0]   out_quo_x,
	output logic [si_pkg::QUO_W-1:0]   out_quo_y,
	output si_pkg::side_t              out_side
);

	localparam int NS = si_pkg::QUO_W;
	localparam int NW = si_pkg::NUM_W;
	localparam int DW = si_pkg::DETM_W;
	localparam int QW = si_pkg::QUO_W;

	// stage registers
	logic [NS-1:0]  vld_s;
	logic [NW-1:0]  rem_x_s [NS];
	logic [NW-1:0]  rem_y_s [NS];
	logic [DW-1:0]  det_s   [NS];
	logic [QW-1:0]  quo_x_s [NS];
	logic [QW-1:0]  quo_y_s [NS];
	si_pkg::side_t  side_s  [NS];

	// stage feeds and step results
	logic [NS-1:0]  feed_v;
	logic [NW-1:0]  feed_rem_x [NS];
	logic [NW-1:0]  feed_rem_y [NS];
	logic [DW-1:0]  feed_det   [NS];
	logic [QW-1:0]  feed_quo_x [NS];
	logic [QW-1:0]  feed_quo_y [NS];
	si_pkg::side_t  feed_side  [NS];
	logic [NW:0]    sub_x      [NS];
	logic [NW:0]    sub_y      [NS];
	logic [NS:0]    rdy;

	// ready chain: a stage takes new data when empty or when it drains
	assign rdy[NS] = out_ready;
	for (genvar g = 0; g < NS; g++) begin : g_rdy
		assign rdy[g] = !vld_s[g] || rdy[g+1];
	end

	// route the module inputs into stage 0 and each stage into the next
	always_comb begin
		feed_v[0]     = in_valid;
		feed_rem_x[0] = in_num_x;
		feed_rem_y[0] = in_num_y;
		feed_det[0]   = in_det;
		feed_quo_x[0] = '0;
		feed_quo_y[0] = '0;
		feed_side[0]  = in_side;
		for (int k = 1; k < NS; k++) begin
			feed_v[k]     = vld_s[k-1];
			feed_rem_x[k] = rem_x_s[k-1];
			feed_rem_y[k] = rem_y_s[k-1];
			feed_det[k]   = det_s[k-1];
			feed_quo_x[k] = quo_x_s[k-1];
			feed_quo_y[k] = quo_y_s[k-1];
			feed_side[k]  = side_s[k-1];
		end
	end

	// trial subtract of the shifted divisor, most significant quotient bit first
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			sub_x[k] = {1'b0, feed_rem_x[k]}
				- ({{(NW+1-DW){1'b0}}, feed_det[k]} << (NS - 1 - k));
			sub_y[k] = {1'b0, feed_rem_y[k]}
				- ({{(NW+1-DW){1'b0}}, feed_det[k]} << (NS - 1 - k));
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= feed_v[k];
				end
			end
		end
	end

	// advance payload, keep the remainder when the trial borrows
	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (rdy[k] && feed_v[k]) begin
				rem_x_s[k] <= sub_x[k][NW] ? feed_rem_x[k] : sub_x[k][NW-1:0];
				rem_y_s[k] <= sub_y[k][NW] ? feed_rem_y[k] : sub_y[k][NW-1:0];
				quo_x_s[k] <= {feed_quo_x[k][QW-2:0], !sub_x[k][NW]};
				quo_y_s[k] <= {feed_quo_y[k][QW-2:0], !sub_y[k][NW]};
				det_s[k]   <= feed_det[k];
				side_s[k]  <= feed_side[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NS-1];
	assign out_quo_x = quo_x_s[NS-1];
	assign out_quo_y = quo_y_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

FILE: rtl/core/segment_intersection.sv
// Top level of the 2D segment intersection pipeline.
// Depends on si_pkg and instantiates si_div for the point division.
//
// Takes one pair of segments per clock while nothing stalls and returns one result
// per pair, in order, through five front stages (differences, products, determinant,
// sign fold, range test and point product), the sixteen stages of the restoring
// divider, one quotient bit each, and the output register. Every stage has its own
// valid bit and takes new data as soon as it is empty or drains, so an output stall
// fills bubbles before it stops the input. hit is on m_axis_tuser; a miss carries
// zero coordinates. The threshold is written over cfg_valid/cfg_data, which is
// always ready, and is read by the range test, so write it only while the pipeline
// is empty.
module segment_intersection (
	input  logic                        clk,
	input  logic                        arst_n,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [si_pkg::IN_W-1:0]     s_axis_tdata,
	// point_x, point_y
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [si_pkg::OUT_W-1:0]    m_axis_tdata,
	// hit
	output logic                        m_axis_tuser,
	// parallel_threshold
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [si_pkg::THR_W-1:0]    cfg_data
);

	localparam int CW = si_pkg::COORD_W;
	localparam int FW = si_pkg::DIFF_W;
	localparam int PW = si_pkg::PROD_W;
	localparam int EW = si_pkg::DET_W;
	localparam int DW = si_pkg::DETM_W;
	localparam int MW = si_pkg::MAG_W;
	localparam int NW = si_pkg::NUM_W;
	localparam int QW = si_pkg::QUO_W;

	// input fields
	logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = s_axis_tdata[0*CW +: CW];
	assign ay0 = s_axis_tdata[1*CW +: CW];
	assign ax1 = s_axis_tdata[2*CW +: CW];
	assign ay1 = s_axis_tdata[3*CW +: CW];
	assign bx0 = s_axis_tdata[4*CW +: CW];
	assign by0 = s_axis_tdata[5*CW +: CW];
	assign bx1 = s_axis_tdata[6*CW +: CW];
	assign by1 = s_axis_tdata[7*CW +: CW];

	// threshold register
	logic [si_pkg::THR_W-1:0] thr_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// ready chain through the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
	logic div_in_ready;
	assign rdy_o = !v_q  || m_axis_tready;
	assign rdy5  = !v_s5 || div_in_ready;
	assign rdy4  = !v_s4 || rdy5;
	assign rdy3  = !v_s3 || rdy4;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: direction and offset differences
	logic signed [FW-1:0] m11_s1, m21_s1, m12_s1, m22_s1, r0_s1, r1_s1;
	logic [CW-1:0]        sx_s1, sy_s1;
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			m11_s1 <= si_pkg::ext_c(ax1) - si_pkg::ext_c(ax0);
			m21_s1 <= si_pkg::ext_c(ay1) - si_pkg::ext_c(ay0);
			m12_s1 <= si_pkg::ext_c(bx0) - si_pkg::ext_c(bx1);
			m22_s1 <= si_pkg::ext_c(by0) - si_pkg::ext_c(by1);
			r0_s1  <= si_pkg::ext_c(bx0) - si_pkg::ext_c(ax0);
			r1_s1  <= si_pkg::ext_c(by0) - si_pkg::ext_c(ay0);
			sx_s1  <= ax0;
			sy_s1  <= ay0;
		end
	end

	// stage 2: the six cross products, direction magnitudes of A
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic [MW-1:0]        magx_s2, magy_s2;
	logic                 negx_s2, negy_s2;
	logic [CW-1:0]        sx_s2, sy_s2;
	logic [FW-1:0]        absx, absy;
	assign absx = m11_s1[FW-1] ? -m11_s1 : m11_s1;
	assign absy = m21_s1[FW-1] ? -m21_s1 : m21_s1;
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			pa_s2   <= m11_s1 * m22_s1;
			pb_s2   <= m21_s1 * m12_s1;
			pc_s2   <= m22_s1 * r0_s1;
			pd_s2   <= m12_s1 * r1_s1;
			pe_s2   <= m11_s1 * r1_s1;
			pf_s2   <= m21_s1 * r0_s1;
			magx_s2 <= absx[MW-1:0];
			magy_s2 <= absy[MW-1:0];
			negx_s2 <= m11_s1[FW-1];
			negy_s2 <= m21_s1[FW-1];
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
		end
	end

	// stage 3: determinant and both numerators
	logic [EW-1:0] det_s3, n0_s3, n1_s3;
	logic [MW-1:0] magx_s3, magy_s3;
	logic          negx_s3, negy_s3;
	logic [CW-1:0] sx_s3, sy_s3;
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			det_s3  <= si_pkg::ext_p(pa_s2) - si_pkg::ext_p(pb_s2);
			n0_s3   <= si_pkg::ext_p(pc_s2) - si_pkg::ext_p(pd_s2);
			n1_s3   <= si_pkg::ext_p(pe_s2) - si_pkg::ext_p(pf_s2);
			magx_s3 <= magx_s2;
			magy_s3 <= magy_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
		end
	end

	// stage 4: fold the determinant sign into the numerators
	logic [DW-1:0] detm_s4;
	logic [EW-1:0] n0_s4, n1_s4;
	logic [MW-1:0] magx_s4, magy_s4;
	logic          negx_s4, negy_s4;
	logic [CW-1:0] sx_s4, sy_s4;
	logic [EW-1:0] det_neg;
	assign det_neg = -det_s3;
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			detm_s4 <= det_s3[EW-1] ? det_neg[DW-1:0] : det_s3[DW-1:0];
			n0_s4   <= det_s3[EW-1] ? -n0_s3 : n0_s3;
			n1_s4   <= det_s3[EW-1] ? -n1_s3 : n1_s3;
			magx_s4 <= magx_s3;
			magy_s4 <= magy_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
		end
	end

	// stage 5: parallel and range tests, dividends of the point offset
	logic          hit_c;
	logic [DW-1:0] detm_s5;
	logic [NW-1:0] px_s5, py_s5;
	si_pkg::side_t side_s5;
	assign hit_c = (detm_s4 > thr_q) && !n0_s4[EW-1] && !n1_s4[EW-1]
		&& (n0_s4[DW-1:0] <= detm_s4) && (n1_s4[DW-1:0] <= detm_s4);
	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			detm_s5         <= detm_s4;
			px_s5           <= n0_s4[DW-1:0] * magx_s4;
			py_s5           <= n0_s4[DW-1:0] * magy_s4;
			side_s5.hit     <= hit_c;
			side_s5.neg_x   <= negx_s4;
			side_s5.neg_y   <= negy_s4;
			side_s5.start_x <= sx_s4;
			side_s5.start_y <= sy_s4;
		end
	end

	// quotient pipeline
	logic          div_out_valid;
	logic [QW-1:0] quo_x, quo_y;
	si_pkg::side_t side_d;
	si_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_det    (detm_s5),
		.in_num_x  (px_s5),
		.in_num_y  (py_s5),
		.in_side   (side_s5),
		.out_valid (div_out_valid),
		.out_ready (rdy_o),
		.out_quo_x (quo_x),
		.out_quo_y (quo_y),
		.out_side  (side_d)
	);

	// output register: start plus signed offset, zero on a miss
	logic          hit_q;
	logic [CW-1:0] ptx_q, pty_q;
	logic [CW-1:0] ptx_c, pty_c;
	assign ptx_c = side_d.neg_x ? side_d.start_x - quo_x : side_d.start_x + quo_x;
	assign pty_c = side_d.neg_y ? side_d.start_y - quo_y : side_d.start_y + quo_y;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= div_out_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (rdy_o && div_out_valid) begin
			hit_q <= side_d.hit;
			ptx_q <= side_d.hit ? ptx_c : '0;
			pty_q <= side_d.hit ? pty_c : '0;
		end
	end

	assign m_axis_tvalid = v_q;
	assign m_axis_tuser  = hit_q;
	assign m_axis_tdata  = {pty_q, ptx_q};

endmodule

FILE: rtl/core/si_checker.sv
// Port-level checks for segment_intersection, attached by the bind at the end.
// Depends on si_pkg and the assertion macros in segment_intersection_defines.svh.
`include "segment_intersection_defines.svh"

module si_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [si_pkg::IN_W-1:0]     s_axis_tdata,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [si_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                        m_axis_tuser,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [si_pkg::THR_W-1:0]    cfg_data
);

	// stall conditions and the full result word
	logic                    in_stall;
	logic                    out_stall;
	logic [si_pkg::OUT_W:0]  out_word;
	assign in_stall  = s_axis_tvalid && !s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tuser, m_axis_tdata};

	// a stalled input transfer holds its segment pair
	`SI_ASSERT_NEXT(a_in_hold, in_stall, s_axis_tvalid && $stable(s_axis_tdata))

	// a stalled result holds its flag and point
	`SI_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

	// a miss carries a zero point
	`SI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

	// a draining or empty output leaves the whole pipeline open to input
	`SI_ASSERT_NOW(a_open_path, !m_axis_tvalid || m_axis_tready, s_axis_tready)

	// a threshold write is taken in the cycle it is offered
	`SI_ASSERT_NOW(a_cfg_taken, cfg_valid && (cfg_data == cfg_data), cfg_ready)

endmodule

bind segment_intersection si_checker u_si_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_data      (cfg_data)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the segment_intersection pipeline.
// Depends on si_pkg and the segment_intersection RTL; computes expected crossings itself.
// Streams directed and random segment pairs through several threshold and idle settings.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import si_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 40;
	localparam logic [THR_W-1:0] THR_MAX      = '1;
	localparam logic [THR_W-1:0] THR_BOUNDARY = 34'd65536;  // 256 x 256 in Q16.16

	// One segment pair, a_start_x in the lowest bits as on s_axis_tdata
	typedef struct packed {
		logic signed [COORD_W-1:0] b_end_y;
		logic signed [COORD_W-1:0] b_end_x;
		logic signed [COORD_W-1:0] b_start_y;
		logic signed [COORD_W-1:0] b_start_x;
		logic signed [COORD_W-1:0] a_end_y;
		logic signed [COORD_W-1:0] a_end_x;
		logic signed [COORD_W-1:0] a_start_y;
		logic signed [COORD_W-1:0] a_start_x;
	} seg_pair_t;

	// One crossing result
	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] point_y;
		logic [COORD_W-1:0] point_x;
	} crossing_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [THR_W-1:0]   cfg_data = '0;

	seg_pair_t          pending_pairs[$];
	crossing_t          awaited_crossings[$];
	seg_pair_t          pair_on_bus;
	crossing_t          want;
	logic [THR_W-1:0]   parallel_thr = '0;
	int                 src_idle_pct = 0;
	int                 sink_stall_pct = 0;
	bit                 src_hold = 1'b0;
	int                 err_count = 0;
	int                 quiet_cycles = 0;

	segment_intersection dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Exact crossing test: determinant, range test without division, truncated point
	function automatic crossing_t predict_crossing(input seg_pair_t p,
			input logic [THR_W-1:0] thr);
		crossing_t r;
		longint dax, day, dbx, dby, rx, ry, det, num0, num1, thr_l, qx, qy, px, py;
		r = '0;
		dax = longint'($signed(p.a_end_x)) - longint'($signed(p.a_start_x));
		day = longint'($signed(p.a_end_y)) - longint'($signed(p.a_start_y));
		dbx = longint'($signed(p.b_start_x)) - longint'($signed(p.b_end_x));
		dby = longint'($signed(p.b_start_y)) - longint'($signed(p.b_end_y));
		rx  = longint'($signed(p.b_start_x)) - longint'($signed(p.a_start_x));
		ry  = longint'($signed(p.b_start_y)) - longint'($signed(p.a_start_y));
		det  = dax * dby - day * dbx;
		num0 = dby * rx - dbx * ry;
		num1 = dax * ry - day * rx;
		// fold the sign so that det is nonnegative
		if (det < 0) begin
			det  = -det;
			num0 = -num0;
			num1 = -num1;
		end
		thr_l = thr;
		if (det <= thr_l)
			return r;
		if (num0 < 0 || num1 < 0 || num0 > det || num1 > det)
			return r;
		qx = (num0 * (dax < 0 ? -dax : dax)) / det;
		qy = (num0 * (day < 0 ? -day : day)) / det;
		px = dax < 0 ? longint'($signed(p.a_start_x)) - qx : longint'($signed(p.a_start_x)) + qx;
		py = day < 0 ? longint'($signed(p.a_start_y)) - qy : longint'($signed(p.a_start_y)) + qy;
		r.hit     = 1'b1;
		r.point_x = px[COORD_W-1:0];
		r.point_y = py[COORD_W-1:0];
		return r;
	endfunction

	function automatic seg_pair_t pair_of(input int ax0, input int ay0, input int ax1,
			input int ay1, input int bx0, input int by0, input int bx1, input int by1);
		seg_pair_t p;
		p.a_start_x = ax0[COORD_W-1:0];
		p.a_start_y = ay0[COORD_W-1:0];
		p.a_end_x   = ax1[COORD_W-1:0];
		p.a_end_y   = ay1[COORD_W-1:0];
		p.b_start_x = bx0[COORD_W-1:0];
		p.b_start_y = by0[COORD_W-1:0];
		p.b_end_x   = bx1[COORD_W-1:0];
		p.b_end_y   = by1[COORD_W-1:0];
		return p;
	endfunction

	function automatic int coord(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Mostly crossing, touching and near-parallel pairs, some degenerate ones, the rest raw noise
	function automatic seg_pair_t random_pair();
		int kind, span, k, g, px, py, ex, ey, ox, oy, tx, ty;
		int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		kind = $urandom_range(99);
		span = 1 << $urandom_range(5, 13);
		ax0 = coord(span);
		ay0 = coord(span);
		ax1 = coord(span);
		ay1 = coord(span);
		bx0 = coord(span);
		by0 = coord(span);
		bx1 = coord(span);
		by1 = coord(span);
		if (kind >= 75)
			return seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
		if (kind < 60) begin
			// pick a point on A and lay B through it, or start B on an endpoint of A
			k  = (kind < 50) ? $urandom_range(256) : $urandom_range(1) * 256;
			px = ax0 + ((ax1 - ax0) * k) / 256;
			py = ay0 + ((ay1 - ay0) * k) / 256;
			ex = coord(span);
			ey = coord(span);
			if (kind < 50) begin
				g   = $urandom_range(512);
				bx0 = px - ex;
				by0 = py - ey;
				bx1 = px + (ex * g) / 256;
				by1 = py + (ey * g) / 256;
			end else begin
				bx0 = px;
				by0 = py;
				bx1 = px + ex;
				by1 = py + ey;
			end
		end else if (kind < 70) begin
			// shifted copy of A with a slight tilt
			ox  = coord(span);
			oy  = coord(span);
			bx0 = ax0 + ox;
			by0 = ay0 + oy;
			bx1 = ax1 + ox + coord(4);
			by1 = ay1 + oy + coord(4);
		end else begin
			case ($urandom_range(2))
				0: begin
					bx0 = ax0;
					by0 = ay0;
					bx1 = ax1;
					by1 = ay1;
				end
				1: begin
					ax1 = ax0;
					ay1 = ay0;
				end
				default: begin
					bx1 = bx0;
					by1 = by0;
				end
			endcase
		end
		if ($urandom_range(1)) begin
			tx  = bx0;
			ty  = by0;
			bx0 = bx1;
			by0 = by1;
			bx1 = tx;
			by1 = ty;
		end
		return pair_of(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
	endfunction

	task automatic log_mismatch(input string what, input longint got, input longint exp_val);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
					exp_val);
	endtask

	// Driver: advance the pending queue, record a prediction on each input transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_crossings.push_back(predict_crossing(pair_on_bus, parallel_thr));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pairs.size() != 0 && !src_hold &&
						$urandom_range(99) >= src_idle_pct) begin
					pair_on_bus = pending_pairs.pop_front();
					s_axis_tdata  <= pair_on_bus;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_crossings.size() == 0) begin
					log_mismatch("result with nothing awaited, hit", m_axis_tuser, 0);
				end else begin
					want = awaited_crossings.pop_front();
					if (m_axis_tuser !== want.hit)
						log_mismatch("hit", m_axis_tuser, want.hit);
					if (m_axis_tdata[COORD_W-1:0] !== want.point_x)
						log_mismatch("point_x", $signed(m_axis_tdata[COORD_W-1:0]),
								$signed(want.point_x));
					if (m_axis_tdata[OUT_W-1:COORD_W] !== want.point_y)
						log_mismatch("point_y", $signed(m_axis_tdata[OUT_W-1:COORD_W]),
								$signed(want.point_y));
				end
			end
		end
	end

	// Watchdog: end the run after too many cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_threshold(input logic [THR_W-1:0] value);
		@(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		parallel_thr = value;
		cfg_valid <= 1'b0;
	endtask

	// Set idle rates and threshold; only called with the pipeline empty
	task automatic set_phase(input logic [THR_W-1:0] thr, input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		write_threshold(thr);
		@(negedge clk);
	endtask

	task automatic queue_pair(input int ax0, input int ay0, input int ax1, input int ay1,
			input int bx0, input int by0, input int bx1, input int by1);
		pending_pairs.push_back(pair_of(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1));
	endtask

	task automatic add_random(input int count);
		repeat (count) pending_pairs.push_back(random_pair());
	endtask

	task automatic drain_pipeline();
		while (pending_pairs.size() != 0 || s_axis_tvalid || awaited_crossings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pairs at zero threshold
		set_phase('0, 0, 0);
		queue_pair(0, 0, 0, 0, 0, 0, 0, 0);                              // all zero
		queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		queue_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		queue_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);             // axes cross
		queue_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		queue_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		queue_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
		queue_pair(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846);
		queue_pair(0, 0, 256, 0, 0, 256, 256, 256);                       // parallel
		queue_pair(0, 0, 1024, 0, 256, 0, 2048, 0);                       // collinear overlap
		queue_pair(0, 0, 512, 512, 512, 512, 1024, 0);                    // A's end touches B's start
		queue_pair(0, 0, 512, 0, 0, 0, 0, 512);                           // start touches start
		queue_pair(0, 0, 1024, 0, 300, 0, 300, 700);                      // B starts inside A
		queue_pair(0, 0, 256, 256, 1024, 0, 1024, 2048);                  // beyond A's end
		queue_pair(0, 0, 2048, 2048, 1024, 0, 1024, 512);                 // beyond B's end
		queue_pair(100, 100, 100, 100, 0, 0, 512, 512);                   // A has zero length
		queue_pair(0, 0, 512, 512, 256, 256, 256, 256);                   // B has zero length
		queue_pair(256, 256, -256, -100, -300, 200, 300, -200);           // negative directions
		queue_pair(1, 0, -1, 0, 0, 1, 0, -1);                             // sub-unit cross
		queue_pair(-3, -7, 5, 9, -5, 6, 7, -8);
		drain_pipeline();

		// Random pairs, no idling
		set_phase('0, 0, 0);
		add_random(300);
		drain_pipeline();

		// Threshold boundary, sparse sender, one pause until everything is back
		set_phase(THR_BOUNDARY, 82, 0);
		queue_pair(0, 0, 256, 0, 128, -128, 128, 128);                    // |det| at threshold
		queue_pair(0, 0, 256, 0, 128, -128, 128, 129);                    // just above it
		add_random(250);
		while (pending_pairs.size() > 125) @(negedge clk);
		src_hold = 1'b1;
		while (s_axis_tvalid || awaited_crossings.size() != 0) @(negedge clk);
		src_hold = 1'b0;
		drain_pipeline();

		// Everything parallel, receiver stalling
		set_phase(THR_MAX, 0, 82);
		add_random(100);
		drain_pipeline();

		// Both sides idle now and then
		set_phase(34'd1 << 24, 21, 21);
		add_random(250);
		drain_pipeline();

		// Random threshold, no idling
		set_phase(THR_W'($urandom_range(0, (1 << 28) - 1)), 0, 0);
		add_random(200);
		drain_pipeline();

		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
